// File: src/aarf_pkg.sv
// Shared types and constants for the adaptive auto rate fallback block.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps
`default_nettype none

package aarf_pkg;

  localparam int RATE_SLOTS = 16;
  localparam int RATE_CAP   = (RATE_SLOTS < 16) ? RATE_SLOTS : 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_FACTOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_FACTOR = 3'd5;

  localparam logic [4:0]  RATE_COUNT_RST     = 5'd12;
  localparam logic [15:0] BASE_TIMEOUT_RST   = 16'd15;
  localparam logic [15:0] MIN_THRESHOLD_RST  = 16'd10;
  localparam logic [15:0] MAX_THRESHOLD_RST  = 16'd50;
  localparam logic [3:0]  SUCCESS_FACTOR_RST = 4'd2;
  localparam logic [3:0]  TIMEOUT_FACTOR_RST = 4'd2;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_UP_SUCCESS = 3'd1;
  localparam logic [2:0] EV_UP_TIMEOUT = 3'd2;
  localparam logic [2:0] EV_DN_RECOVER = 3'd3;
  localparam logic [2:0] EV_DN_TWOFAIL = 3'd4;

  localparam logic [1:0] TRY_ONE = 2'd1;
  localparam logic [1:0] TRY_TWO = 2'd2;

  typedef struct packed {
    logic [4:0]  rate_count;
    logic [15:0] base_timeout;
    logic [15:0] min_threshold;
    logic [15:0] max_threshold;
    logic [3:0]  success_factor;
    logic [3:0]  timeout_factor;
  } cfg_t;

  typedef struct packed {
    logic [3:0] rate_index;
    logic [2:0] event_code;
    logic [1:0] first_try_count;
  } res_t;

endpackage

`default_nettype wire

// File: src/adaptive_auto_rate_fallback_top.sv
// Top level of the adaptive auto rate fallback controller.
// Depends on aarf_pkg, aarf_cfg and aarf_engine.
//
// Usage:
//   Input channel (in_valid / in_ready / attempt_ok) carries one beat per
//   transmit attempt: attempt_ok high for an acknowledged attempt.
//   Output channel (out_valid / out_ready) returns one beat per input beat:
//   rate_index after the attempt, event_code and first_try_count.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are registered;
//   issue them only while no beat is in flight. Unknown indexes are ignored.
// Timing:
//   An input register feeds the combinational state update, whose result
//   is held in the output register. Throughput, bounded by the update loop
//   on the rate state, is one beat per cycle while out_ready stays high.
//   When the receiver stalls, the output register holds its beat and the
//   input register takes one more; in_ready then drops until out_ready.
// Reset:
//   rst clears both pipeline stages, loads the register reset values and
//   returns the rate state to rate 0, threshold 10, timeout 15.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_auto_rate_fallback_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            attempt_ok,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [3:0]                           rate_index,
  output logic [2:0]                           event_code,
  output logic [1:0]                           first_try_count,
  input  wire logic                            cfg_we,
  input  wire logic [aarf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aarf_pkg::CFG_DATA_W-1:0] cfg_data
);

  aarf_pkg::cfg_t cfg;
  aarf_pkg::res_t res;

  logic in_full;
  logic in_ok;
  logic advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  aarf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aarf_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .attempt_ok (in_ok),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_ok <= attempt_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rate_index      <= res.rate_index;
      event_code      <= res.event_code;
      first_try_count <= res.first_try_count;
    end
  end

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_ok))
    else $error("input stage lost a beat while stalled");

  a_advance_gives_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("output not valid after an update");

  a_stall_holds_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rate_index) &&
                                $stable(event_code))
    else $error("output beat changed while stalled");

endmodule

`default_nettype wire

// File: src/aarf_cfg.sv
// Configuration register file of the rate controller.
// Depends on aarf_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module aarf_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [aarf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [aarf_pkg::CFG_DATA_W-1:0]    cfg_data,
  output aarf_pkg::cfg_t                          cfg
);

  aarf_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rate_count     <= aarf_pkg::RATE_COUNT_RST;
      regs.base_timeout   <= aarf_pkg::BASE_TIMEOUT_RST;
      regs.min_threshold  <= aarf_pkg::MIN_THRESHOLD_RST;
      regs.max_threshold  <= aarf_pkg::MAX_THRESHOLD_RST;
      regs.success_factor <= aarf_pkg::SUCCESS_FACTOR_RST;
      regs.timeout_factor <= aarf_pkg::TIMEOUT_FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        aarf_pkg::REG_RATE_COUNT:     regs.rate_count     <= cfg_data[4:0];
        aarf_pkg::REG_BASE_TIMEOUT:   regs.base_timeout   <= cfg_data;
        aarf_pkg::REG_MIN_THRESHOLD:  regs.min_threshold  <= cfg_data;
        aarf_pkg::REG_MAX_THRESHOLD:  regs.max_threshold  <= cfg_data;
        aarf_pkg::REG_SUCCESS_FACTOR: regs.success_factor <= cfg_data[3:0];
        aarf_pkg::REG_TIMEOUT_FACTOR: regs.timeout_factor <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// File: src/aarf_engine.sv
// Adaptive rate state and the combinational update for one attempt outcome.
// Depends on aarf_pkg for cfg_t, res_t and the event codes.
`timescale 1ns / 1ps
`default_nettype none

module aarf_engine (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       attempt_ok,
  input  aarf_pkg::cfg_t  cfg,
  output aarf_pkg::res_t  res
);

  localparam logic [4:0] RATE_CAP5 = 5'(aarf_pkg::RATE_CAP);

  logic [3:0]  current_rate, current_rate_next;
  logic [15:0] tick_timer, tick_timer_next;
  logic [15:0] success_run, success_run_next;
  logic [1:0]  failure_run, failure_run_next;
  logic        in_recovery, in_recovery_next;
  logic [15:0] success_threshold, success_threshold_next;
  logic [15:0] timeout_limit, timeout_limit_next;

  logic [4:0]  usable;
  logic        can_raise;
  logic [15:0] timer_inc;
  logic [15:0] run_inc;
  logic [1:0]  fail_inc;
  logic [15:0] timeout_scaled;
  logic [15:0] threshold_scaled;
  logic [2:0]  ev;

  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] mul_sat(input logic [15:0] a, input logic [3:0] k);
    logic [19:0] p;
    p = {4'd0, a} * {16'd0, k};
    return (p[19:16] != 4'd0) ? 16'hFFFF : p[15:0];
  endfunction

  always_comb begin
    if (cfg.rate_count == 5'd0) begin
      usable = 5'd1;
    end else if (cfg.rate_count > RATE_CAP5) begin
      usable = RATE_CAP5;
    end else begin
      usable = cfg.rate_count;
    end
  end

  assign can_raise        = ({1'b0, current_rate} + 5'd1) < usable;
  assign timer_inc        = inc_sat(tick_timer);
  assign run_inc          = inc_sat(success_run);
  assign fail_inc         = failure_run + 2'd1;
  assign timeout_scaled   = mul_sat(timeout_limit, cfg.timeout_factor);
  assign threshold_scaled = mul_sat(success_threshold, cfg.success_factor);

  always_comb begin
    current_rate_next      = current_rate;
    tick_timer_next        = timer_inc;
    success_run_next       = success_run;
    failure_run_next       = failure_run;
    in_recovery_next       = in_recovery;
    success_threshold_next = success_threshold;
    timeout_limit_next     = timeout_limit;
    ev                     = aarf_pkg::EV_NONE;
    if (attempt_ok) begin
      success_run_next = run_inc;
      failure_run_next = 2'd0;
      in_recovery_next = 1'b0;
      if (can_raise) begin
        if (run_inc >= success_threshold) begin
          ev = aarf_pkg::EV_UP_SUCCESS;
        end else if (timer_inc >= timeout_limit) begin
          ev = aarf_pkg::EV_UP_TIMEOUT;
        end
      end
      if (ev != aarf_pkg::EV_NONE) begin
        current_rate_next = current_rate + 4'd1;
        tick_timer_next   = 16'd0;
        success_run_next  = 16'd0;
        in_recovery_next  = 1'b1;
      end
    end else begin
      failure_run_next = fail_inc;
      success_run_next = 16'd0;
      if (in_recovery) begin
        ev = aarf_pkg::EV_DN_RECOVER;
        timeout_limit_next = (timeout_scaled > cfg.min_threshold) ?
                             timeout_scaled : cfg.min_threshold;
        success_threshold_next = (threshold_scaled < cfg.max_threshold) ?
                                 threshold_scaled : cfg.max_threshold;
      end else if (fail_inc >= 2'd2) begin
        ev = aarf_pkg::EV_DN_TWOFAIL;
        timeout_limit_next     = cfg.base_timeout;
        success_threshold_next = cfg.min_threshold;
      end
      if (ev != aarf_pkg::EV_NONE) begin
        tick_timer_next  = 16'd0;
        failure_run_next = 2'd0;
        if (current_rate != 4'd0) begin
          current_rate_next = current_rate - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_rate      <= 4'd0;
      tick_timer        <= 16'd0;
      success_run       <= 16'd0;
      failure_run       <= 2'd0;
      in_recovery       <= 1'b0;
      success_threshold <= aarf_pkg::MIN_THRESHOLD_RST;
      timeout_limit     <= aarf_pkg::BASE_TIMEOUT_RST;
    end else if (step) begin
      current_rate      <= current_rate_next;
      tick_timer        <= tick_timer_next;
      success_run       <= success_run_next;
      failure_run       <= failure_run_next;
      in_recovery       <= in_recovery_next;
      success_threshold <= success_threshold_next;
      timeout_limit     <= timeout_limit_next;
    end
  end

  assign res.rate_index      = current_rate_next;
  assign res.event_code      = ev;
  assign res.first_try_count = (in_recovery_next || failure_run_next != 2'd0) ?
                               aarf_pkg::TRY_ONE : aarf_pkg::TRY_TWO;

  a_up_enters_recovery: assert property (@(posedge clk) disable iff (rst)
    step && (res.event_code == aarf_pkg::EV_UP_SUCCESS ||
             res.event_code == aarf_pkg::EV_UP_TIMEOUT) |=> in_recovery)
    else $error("rate increase did not enter recovery");

  a_event_clears_timer: assert property (@(posedge clk) disable iff (rst)
    step && res.event_code != aarf_pkg::EV_NONE |=> tick_timer == 16'd0)
    else $error("timer not cleared after rate change");

  a_idle_holds_rate: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(current_rate) && $stable(timeout_limit))
    else $error("state moved without a step");

  a_failure_run_bounded: assert property (@(posedge clk) disable iff (rst)
    failure_run == 2'd0 || failure_run == 2'd1)
    else $error("failure run went past one");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking testbench for adaptive_auto_rate_fallback_top: directed rate
// moves, saturation and rate-limit cases, then paced random attempt traffic.
// Depends on aarf_pkg and the RTL under src.
module tb_top;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 100;
  localparam logic [aarf_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [aarf_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            attempt_ok = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [3:0]                      rate_index;
  logic [2:0]                      event_code;
  logic [1:0]                      first_try_count;
  logic                            cfg_we = 1'b0;
  logic [aarf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [aarf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  aarf_pkg::cfg_t shadow_cfg;
  logic [3:0]     cur_rate;
  logic [15:0]    tick_cnt;
  logic [15:0]    ok_run;
  logic [15:0]    thr_now;
  logic [15:0]    tmo_now;
  logic [1:0]     miss_run;
  logic           recovering;

  aarf_pkg::res_t decisions_due[$];
  aarf_pkg::res_t rx_want;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_on = 1'b0;
  event hold_kick;
  int   fail_count = 0;
  int   attempts_sent = 0;
  int   decisions_seen = 0;
  int   settings_used = 0;
  int   quiet_cycles = 0;
  int   ev_hits[5] = '{default: 0};

  adaptive_auto_rate_fallback_top u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .attempt_ok      (attempt_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .rate_index      (rate_index),
    .event_code      (event_code),
    .first_try_count (first_try_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] scale16(input logic [15:0] a, input logic [3:0] k);
    logic [19:0] p;
    p = 20'(a) * 20'(k);
    return (p > 20'hFFFF) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic logic [4:0] usable_rates(input logic [4:0] n);
    if (n == 5'd0) return 5'd1;
    if (n > 5'(aarf_pkg::RATE_CAP)) return 5'(aarf_pkg::RATE_CAP);
    return n;
  endfunction

  task automatic reset_shadow();
    shadow_cfg.rate_count     = aarf_pkg::RATE_COUNT_RST;
    shadow_cfg.base_timeout   = aarf_pkg::BASE_TIMEOUT_RST;
    shadow_cfg.min_threshold  = aarf_pkg::MIN_THRESHOLD_RST;
    shadow_cfg.max_threshold  = aarf_pkg::MAX_THRESHOLD_RST;
    shadow_cfg.success_factor = aarf_pkg::SUCCESS_FACTOR_RST;
    shadow_cfg.timeout_factor = aarf_pkg::TIMEOUT_FACTOR_RST;
    cur_rate   = 4'd0;
    tick_cnt   = 16'd0;
    ok_run     = 16'd0;
    miss_run   = 2'd0;
    recovering = 1'b0;
    thr_now    = aarf_pkg::MIN_THRESHOLD_RST;
    tmo_now    = aarf_pkg::BASE_TIMEOUT_RST;
  endtask

  task automatic next_rate_decision(input logic ok, output aarf_pkg::res_t r);
    logic [2:0]  ev;
    logic [15:0] v;
    ev = aarf_pkg::EV_NONE;
    tick_cnt = bump16(tick_cnt);
    if (ok) begin
      ok_run = bump16(ok_run);
      miss_run = 2'd0;
      recovering = 1'b0;
      if ({1'b0, cur_rate} + 5'd1 < usable_rates(shadow_cfg.rate_count)) begin
        if (ok_run >= thr_now) ev = aarf_pkg::EV_UP_SUCCESS;
        else if (tick_cnt >= tmo_now) ev = aarf_pkg::EV_UP_TIMEOUT;
        if (ev != aarf_pkg::EV_NONE) begin
          cur_rate = cur_rate + 4'd1;
          tick_cnt = 16'd0;
          ok_run = 16'd0;
          recovering = 1'b1;
        end
      end
    end else begin
      miss_run = miss_run + 2'd1;
      ok_run = 16'd0;
      if (recovering) begin
        ev = aarf_pkg::EV_DN_RECOVER;
        v = scale16(tmo_now, shadow_cfg.timeout_factor);
        tmo_now = (v > shadow_cfg.min_threshold) ? v : shadow_cfg.min_threshold;
        v = scale16(thr_now, shadow_cfg.success_factor);
        thr_now = (v < shadow_cfg.max_threshold) ? v : shadow_cfg.max_threshold;
      end else if (miss_run >= 2'd2) begin
        ev = aarf_pkg::EV_DN_TWOFAIL;
        tmo_now = shadow_cfg.base_timeout;
        thr_now = shadow_cfg.min_threshold;
      end
      if (ev != aarf_pkg::EV_NONE) begin
        tick_cnt = 16'd0;
        miss_run = 2'd0;
        if (cur_rate != 4'd0) cur_rate = cur_rate - 4'd1;
      end
    end
    r.rate_index = cur_rate;
    r.event_code = ev;
    r.first_try_count = (recovering || miss_run != 2'd0) ?
                        aarf_pkg::TRY_ONE : aarf_pkg::TRY_TWO;
  endtask

  task automatic report_miss(input string what, input logic [3:0] want, input logic [3:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
  endtask

  task automatic set_pacing(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_attempt(input logic ok);
    aarf_pkg::res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    attempt_ok <= ok;
    do @(posedge clk); while (in_ready !== 1'b1);
    next_rate_decision(ok, r);
    decisions_due.push_back(r);
    ev_hits[r.event_code]++;
    attempts_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aarf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aarf_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      aarf_pkg::REG_RATE_COUNT:     shadow_cfg.rate_count = val[4:0];
      aarf_pkg::REG_BASE_TIMEOUT:   shadow_cfg.base_timeout = val;
      aarf_pkg::REG_MIN_THRESHOLD:  shadow_cfg.min_threshold = val;
      aarf_pkg::REG_MAX_THRESHOLD:  shadow_cfg.max_threshold = val;
      aarf_pkg::REG_SUCCESS_FACTOR: shadow_cfg.success_factor = val[3:0];
      aarf_pkg::REG_TIMEOUT_FACTOR: shadow_cfg.timeout_factor = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Call only with no beat in flight.
  task automatic load_settings(input aarf_pkg::cfg_t c);
    write_reg(aarf_pkg::REG_RATE_COUNT, {11'($urandom), c.rate_count});
    write_reg(aarf_pkg::REG_BASE_TIMEOUT, c.base_timeout);
    write_reg(aarf_pkg::REG_MIN_THRESHOLD, c.min_threshold);
    write_reg(aarf_pkg::REG_MAX_THRESHOLD, c.max_threshold);
    write_reg(aarf_pkg::REG_SUCCESS_FACTOR, {12'($urandom), c.success_factor});
    write_reg(aarf_pkg::REG_TIMEOUT_FACTOR, {12'($urandom), c.timeout_factor});
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic aarf_pkg::cfg_t pick_settings(input int p);
    aarf_pkg::cfg_t c;
    if (p == 0) begin
      c = '0;
    end else if (p == 1) begin
      c = '1;
    end else begin
      c.rate_count = 5'($urandom_range(0, 31));
      c.base_timeout = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
      c.min_threshold = 16'($urandom_range(0, 30));
      c.max_threshold = 16'($urandom_range(0, 80));
      c.success_factor = 4'($urandom);
      c.timeout_factor = 4'($urandom);
    end
    return c;
  endfunction

  // Success runs broken by short failure bursts, with some noise mixed in.
  task automatic drive_traffic(input int n);
    int ok_left;
    int miss_left;
    ok_left = 0;
    miss_left = 0;
    for (int i = 0; i < n; i++) begin
      if (ok_left == 0 && miss_left == 0) begin
        ok_left = ($urandom_range(4) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 40);
        miss_left = $urandom_range(1, 3);
      end
      if ($urandom_range(9) == 0) begin
        send_attempt(1'($urandom_range(1)));
      end else if (ok_left != 0) begin
        send_attempt(1'b1);
        ok_left--;
      end else begin
        send_attempt(1'b0);
        miss_left--;
      end
    end
  endtask

  task automatic test_basic_events();
    set_pacing(0, 0);
    repeat (10) send_attempt(1'b1);
    repeat (2) send_attempt(1'b0);
    send_attempt(1'b1);
    repeat (2) send_attempt(1'b0);
  endtask

  task automatic test_timeout_raise();
    aarf_pkg::cfg_t c;
    wait_idle();
    c = shadow_cfg;
    c.base_timeout = 16'd3;
    load_settings(c);
    send_attempt(1'b1);
    repeat (2) send_attempt(1'b0);
    repeat (3) send_attempt(1'b1);
  endtask

  task automatic test_scale_saturation();
    aarf_pkg::cfg_t c;
    wait_idle();
    c = shadow_cfg;
    c.min_threshold = 16'd1;
    c.max_threshold = 16'hFFFF;
    c.success_factor = 4'd15;
    c.timeout_factor = 4'd15;
    load_settings(c);
    send_attempt(1'b1);
    repeat (2) send_attempt(1'b0);
    send_attempt(1'b1);
    repeat (5) send_attempt(1'b0);
  endtask

  task automatic test_rate_cap();
    aarf_pkg::cfg_t c;
    wait_idle();
    c = shadow_cfg;
    c.rate_count = 5'd31;
    c.min_threshold = 16'd1;
    load_settings(c);
    send_attempt(1'b1);
    repeat (2) send_attempt(1'b0);
    repeat (16) send_attempt(1'b1);
    wait_idle();
    c.rate_count = 5'd2;
    load_settings(c);
    repeat (2) send_attempt(1'b0);
    repeat (2) send_attempt(1'b1);
  endtask

  task automatic test_single_rate();
    aarf_pkg::cfg_t c;
    wait_idle();
    set_pacing(0, 0);
    c = shadow_cfg;
    c.rate_count = 5'd0;
    c.min_threshold = 16'hFFFF;
    c.base_timeout = 16'hFFFF;
    load_settings(c);
    send_attempt(1'b1);
    repeat (2) send_attempt(1'b0);
    repeat (200) send_attempt(1'b1);
    wait_idle();
    c.rate_count = 5'd16;
    load_settings(c);
    repeat (2) send_attempt(1'b1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_pacing(0, 0);
    -> hold_kick;
    drive_traffic(40);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      load_settings(pick_settings(p));
      case (p % 4)
        0: set_pacing(0, 0);
        1: set_pacing(73, 0);
        2: set_pacing(0, 73);
        default: set_pacing(24, 24);
      endcase
      drive_traffic(PHASE_ITEMS);
    end
  endtask

  always begin
    @(hold_kick);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && out_ready) begin
        decisions_seen++;
        if (decisions_due.size() == 0) begin
          report_miss("unexpected result beat, rate_index", 4'd0, rate_index);
        end else begin
          rx_want = decisions_due.pop_front();
          if (rate_index !== rx_want.rate_index)
            report_miss("rate_index", rx_want.rate_index, rate_index);
          if (event_code !== rx_want.event_code)
            report_miss("event_code", 4'(rx_want.event_code), 4'(event_code));
          if (first_try_count !== rx_want.first_try_count)
            report_miss("first_try_count", 4'(rx_want.first_try_count), 4'(first_try_count));
        end
      end
      out_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("adaptive_auto_rate_fallback_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_shadow();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_basic_events();
    test_timeout_raise();
    test_scale_saturation();
    test_rate_cap();
    test_single_rate();
    test_backpressure();
    test_random_phases();
    wait_idle();
    $display("Run covered %0d attempts and %0d result beats over %0d register settings",
             attempts_sent, decisions_seen, settings_used);
    $display("Rate moves: %0d up on successes, %0d up on timeout,",
             ev_hits[aarf_pkg::EV_UP_SUCCESS], ev_hits[aarf_pkg::EV_UP_TIMEOUT]);
    $display("  %0d down in recovery, %0d down on two failures",
             ev_hits[aarf_pkg::EV_DN_RECOVER], ev_hits[aarf_pkg::EV_DN_TWOFAIL]);
    if (fail_count == 0) begin
      $display("adaptive_auto_rate_fallback_top verification clean");
    end else begin
      $display("adaptive_auto_rate_fallback_top verification failed");
    end
    $finish;
  end

endmodule
